FILE: rtl/tlt_pkg.sv
// Shared types and constants for the timed lock table.
`default_nettype none

package tlt_pkg;

    localparam int DEV_W  = 16;
    localparam int PATH_W = 32;
    localparam int TIME_W = 32;
    localparam int SLOT_W = 5;
    localparam int STAT_W = 2;

    localparam logic [TIME_W-1:0] HOLD_RESET = 32'd300;

    localparam logic CMD_ACQUIRE = 1'b0;
    localparam logic CMD_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_LOCKED = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;

    typedef struct packed {
        logic [DEV_W-1:0]  device;
        logic [PATH_W-1:0] path;
        logic [TIME_W-1:0] expiry;
    } t_entry;

    // Outcome of testing one entry against the request.
    typedef struct packed {
        logic hit;
        logic free;
    } t_cmp;

    // Write strobes into the table: owner fields and expiry separately.
    typedef struct packed {
        logic owner;
        logic expiry;
    } t_wr_en;

endpackage

`default_nettype wire

FILE: rtl/tlt_mem.sv
// Lock table storage: one write port with per-field strobes, one registered read port.
`default_nettype none

module tlt_mem #(
    parameter int NUM_LOCKS = 32,
    parameter int IW        = 5
) (
    input  wire logic                          i_clk,
    input  wire tlt_pkg::t_wr_en               i_we,
    input  wire logic [IW-1:0]                 i_waddr,
    input  wire tlt_pkg::t_entry               i_wdata,
    input  wire logic [IW-1:0]                 i_raddr,
    output tlt_pkg::t_entry                    o_rdata
);
    import tlt_pkg::*;

    logic [DEV_W-1:0]  r_dev  [NUM_LOCKS];
    logic [PATH_W-1:0] r_path [NUM_LOCKS];
    logic [TIME_W-1:0] r_exp  [NUM_LOCKS];
    t_entry            r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we.owner) begin
            r_dev[i_waddr]  <= i_wdata.device;
            r_path[i_waddr] <= i_wdata.path;
        end
        if (i_we.expiry) begin
            r_exp[i_waddr] <= i_wdata.expiry;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata.device <= r_dev[i_raddr];
        r_rdata.path   <= r_path[i_raddr];
        r_rdata.expiry <= r_exp[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: rtl/tlt_cmp.sv
// Entry test unit: owner match with live expiry, and free-entry detect.
`default_nettype none

module tlt_cmp (
    input  wire tlt_pkg::t_entry          i_entry,
    input  wire logic [tlt_pkg::DEV_W-1:0]  i_device,
    input  wire logic [tlt_pkg::PATH_W-1:0] i_path,
    input  wire logic [tlt_pkg::TIME_W-1:0] i_now,
    output tlt_pkg::t_cmp                 o_res
);
    import tlt_pkg::*;

    // Expiry at or after now keeps the lock held.
    assign o_res.hit  = (i_entry.path == i_path) && (i_entry.device == i_device)
                        && (i_entry.expiry >= i_now);
    assign o_res.free = (i_entry.expiry == '0);

endmodule

`default_nettype wire

FILE: rtl/timed_lock_table_unit.sv
// Timed lock table: top level with sequencer, table storage and entry test unit.
//
// Usage:
//   Input channel (i_valid / o_ready) carries one request: acquire (i_cmd = 0)
//   with device, path and current time, or release (i_cmd = 1) of one slot.
//   Output channel (o_valid / i_ready) returns one status and slot per request.
//   i_cfg_we / i_cfg_wdata write the hold time; write it only while idle.
// Timing:
//   An acquire scans the table from the top index down, one entry per cycle
//   through the single read port and the entry test unit; the scan stops
//   early on a live match; a release skips the scan. One request is in work
//   at a time: o_ready is high only when idle.
// Reset:
//   i_rst_n is synchronous, active low. After reset a clearing pass writes
//   every table entry to zero, with o_ready held low; hold-time writes are
//   still taken during the pass. Hold time resets to 300.
// Stall:
//   A finished result sits in the output register until taken; the next
//   request is accepted meanwhile, and its result waits until the register
//   frees up.
`default_nettype none

module timed_lock_table_unit #(
    parameter int NUM_LOCKS = 32
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_we,
    input  wire logic [tlt_pkg::TIME_W-1:0]     i_cfg_wdata,
    input  wire logic                           i_valid,
    output logic                                o_ready,
    input  wire logic                           i_cmd,
    input  wire logic [tlt_pkg::DEV_W-1:0]      i_device_id,
    input  wire logic [tlt_pkg::PATH_W-1:0]     i_object_path,
    input  wire logic [tlt_pkg::TIME_W-1:0]     i_now,
    input  wire logic [tlt_pkg::SLOT_W-1:0]     i_release_slot,
    output logic                                o_valid,
    input  wire logic                           i_ready,
    output logic [tlt_pkg::STAT_W-1:0]          o_status,
    output logic [tlt_pkg::SLOT_W-1:0]          o_slot
);
    import tlt_pkg::*;

    localparam int IW = (NUM_LOCKS > 1) ? $clog2(NUM_LOCKS) : 1;
    localparam logic [IW-1:0] TOP_IDX = IW'(NUM_LOCKS - 1);

    typedef enum logic [4:0] {
        S_CLEAR = 5'b00001,
        S_IDLE  = 5'b00010,
        S_SCAN  = 5'b00100,
        S_WRITE = 5'b01000,
        S_DONE  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [IW-1:0]       r_idx, n_idx;          // read / clear address
    logic                r_more, n_more;        // reads still to issue
    logic                r_pend, n_pend;        // read data valid this cycle
    logic [IW-1:0]       r_pidx, n_pidx;        // index of the data in hand
    logic                r_have_free, n_have_free;
    logic [IW-1:0]       r_free_idx, n_free_idx;
    logic [TIME_W-1:0]   r_hold_time;

    // Latched request
    logic                r_cmd;
    logic [DEV_W-1:0]    r_dev;
    logic [PATH_W-1:0]   r_path;
    logic [TIME_W-1:0]   r_now;
    logic [SLOT_W-1:0]   r_rel;

    // Finished result, then output register
    logic [STAT_W-1:0]   r_res_status, n_res_status;
    logic [SLOT_W-1:0]   r_res_slot, n_res_slot;
    logic                r_o_valid, n_o_valid;
    logic [STAT_W-1:0]   r_o_status, n_o_status;
    logic [SLOT_W-1:0]   r_o_slot, n_o_slot;

    t_wr_en              mem_we;
    logic [IW-1:0]       mem_waddr;
    t_entry              mem_wdata;
    t_entry              mem_rdata;
    t_cmp                cmp_res;

    logic                in_xfer;
    logic                rel_in_range;

    assign in_xfer      = i_valid && o_ready;
    assign o_ready      = (r_state == S_IDLE);
    assign rel_in_range = ({{(32 - SLOT_W){1'b0}}, r_rel} < 32'(NUM_LOCKS));

    tlt_mem #(
        .NUM_LOCKS (NUM_LOCKS),
        .IW        (IW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_idx),
        .o_rdata (mem_rdata)
    );

    tlt_cmp u_cmp (
        .i_entry  (mem_rdata),
        .i_device (r_dev),
        .i_path   (r_path),
        .i_now    (r_now),
        .o_res    (cmp_res)
    );

    // Table write port: clearing pass, claim of a free entry, or release.
    always_comb begin
        mem_we    = '0;
        mem_waddr = r_idx;
        mem_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                mem_we.owner  = 1'b1;
                mem_we.expiry = 1'b1;
            end
            S_WRITE: begin
                if (r_cmd == CMD_ACQUIRE) begin
                    mem_waddr        = r_free_idx;
                    mem_we.owner     = r_have_free;
                    mem_we.expiry    = r_have_free;
                    mem_wdata.device = r_dev;
                    mem_wdata.path   = r_path;
                    mem_wdata.expiry = r_now + r_hold_time;   // wraps at 32 bits
                end else begin
                    mem_waddr     = IW'(r_rel);
                    mem_we.expiry = rel_in_range;
                end
            end
            default: begin
            end
        endcase
    end

    // Sequencer
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_more       = r_more;
        n_pend       = 1'b0;
        n_pidx       = r_pidx;
        n_have_free  = r_have_free;
        n_free_idx   = r_free_idx;
        n_res_status = r_res_status;
        n_res_slot   = r_res_slot;
        n_o_valid    = r_o_valid && !i_ready;
        n_o_status   = r_o_status;
        n_o_slot     = r_o_slot;

        case (r_state)
            S_CLEAR: begin
                // sweep down to entry 0, then open for requests
                if (r_idx == '0) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx - 1'b1;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_have_free = 1'b0;
                    n_free_idx  = '0;
                    if (i_cmd == CMD_ACQUIRE) begin
                        n_idx   = TOP_IDX;
                        n_more  = 1'b1;
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_WRITE;
                    end
                end
            end
            S_SCAN: begin
                // issue the next read while testing the entry just returned
                n_pend = r_more;
                n_pidx = r_idx;
                if (r_more) begin
                    if (r_idx == '0) begin
                        n_more = 1'b0;
                    end else begin
                        n_idx = r_idx - 1'b1;
                    end
                end
                if (r_pend) begin
                    if (cmp_res.hit) begin
                        n_res_status = ST_LOCKED;
                        n_res_slot   = '0;
                        n_more       = 1'b0;
                        n_pend       = 1'b0;
                        n_state      = S_DONE;
                    end else begin
                        if (cmp_res.free && !r_have_free) begin
                            n_have_free = 1'b1;
                            n_free_idx  = r_pidx;
                        end
                        if (r_pidx == '0) begin
                            n_state = S_WRITE;
                        end
                    end
                end
            end
            S_WRITE: begin
                if (r_cmd == CMD_RELEASE) begin
                    n_res_status = ST_OK;
                    n_res_slot   = r_rel;
                end else if (r_have_free) begin
                    n_res_status = ST_OK;
                    n_res_slot   = SLOT_W'(r_free_idx);
                end else begin
                    n_res_status = ST_FULL;
                    n_res_slot   = '0;
                end
                n_state = S_DONE;
            end
            S_DONE: begin
                // hand over once the output register is empty or being drained
                if (!r_o_valid || i_ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_slot   = r_res_slot;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= TOP_IDX;
            r_more      <= 1'b0;
            r_pend      <= 1'b0;
            r_have_free <= 1'b0;
            r_o_valid   <= 1'b0;
            r_hold_time <= HOLD_RESET;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_more      <= n_more;
            r_pend      <= n_pend;
            r_have_free <= n_have_free;
            r_o_valid   <= n_o_valid;
            if (i_cfg_we) begin
                r_hold_time <= i_cfg_wdata;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_pidx       <= n_pidx;
        r_free_idx   <= n_free_idx;
        r_res_status <= n_res_status;
        r_res_slot   <= n_res_slot;
        r_o_status   <= n_o_status;
        r_o_slot     <= n_o_slot;
        if (in_xfer) begin
            r_cmd  <= i_cmd;
            r_dev  <= i_device_id;
            r_path <= i_object_path;
            r_now  <= i_now;
            r_rel  <= i_release_slot;
        end
    end

    assign o_valid  = r_o_valid;
    assign o_status = r_o_status;
    assign o_slot   = r_o_slot;

`ifndef NO_ASSERTIONS
    // One request at a time: the port closes right after a transfer in.
    a_busy_after_xfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> !o_ready)
        else $error("input accepted on consecutive cycles");

    // Only defined status codes leave the block.
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == ST_OK || o_status == ST_LOCKED || o_status == ST_FULL))
        else $error("undefined status code on output");

    // A denied request reports slot zero.
    a_denied_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != ST_OK) |-> (o_slot == '0))
        else $error("nonzero slot on a denial");

    // A pending result is not overwritten while stalled.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=> (o_valid && $stable(o_status) && $stable(o_slot)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
